// File: hdl/mcw_pkg.sv
package mcw_pkg;

  localparam int MAX_DIMS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_COORDS = 4;
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 16;
  localparam int INDEX_W    = 32;
  localparam int WEIGHT_W   = 17;
  localparam int COUNT_W    = 5;
  localparam int NDIM_W     = 3;

  localparam int IN_DATA_W  = NUM_COORDS * COORD_W;
  localparam int OUT_DATA_W = 56;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_NUM_DIMS     = 3'd0,
    REG_DIM_SIZES    = 3'd1,
    REG_STRIDE_ZERO  = 3'd2,
    REG_STRIDE_ONE   = 3'd3,
    REG_STRIDE_TWO   = 3'd4,
    REG_STRIDE_THREE = 3'd5
  } reg_idx_e;

  localparam logic [NDIM_W-1:0]  NUM_DIMS_RST = 3'd1;
  localparam logic [INDEX_W-1:0] STRIDE0_RST  = 32'd1;

  // per-corner control that rides along the weight pipeline
  typedef struct packed {
    logic               last;
    logic               none;
    logic [COUNT_W-1:0] count;
  } corner_ctl_t;

endpackage

// File: hdl/mcw_regs.sv
module mcw_regs (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [mcw_pkg::CFG_ADDR_W-1:0]                paddr,
  input  logic [mcw_pkg::CFG_DATA_W-1:0]                pwdata,
  output logic [mcw_pkg::CFG_DATA_W-1:0]                prdata,
  output logic                                          pready,
  output logic [mcw_pkg::NDIM_W-1:0]                    num_dims_o,
  output logic [mcw_pkg::NUM_COORDS*mcw_pkg::SIZE_W-1:0] dim_sizes_o,
  output logic [mcw_pkg::NUM_COORDS-1:0][mcw_pkg::INDEX_W-1:0] stride_o
);

  logic [mcw_pkg::NDIM_W-1:0]                          num_dims_q;
  logic [mcw_pkg::NUM_COORDS*mcw_pkg::SIZE_W-1:0]      dim_sizes_q;
  logic [mcw_pkg::NUM_COORDS-1:0][mcw_pkg::INDEX_W-1:0] stride_q;
  logic [2:0]                                          addr_idx;
  logic                                                wr_en;

  assign pready   = 1'b1;
  assign addr_idx = paddr[5:3];
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q  <= mcw_pkg::NUM_DIMS_RST;
      dim_sizes_q <= '0;
      stride_q    <= {{((mcw_pkg::NUM_COORDS-1)*mcw_pkg::INDEX_W){1'b0}},
                      mcw_pkg::STRIDE0_RST};
    end else if (wr_en) begin
      unique case (addr_idx)
        mcw_pkg::REG_NUM_DIMS:     num_dims_q  <= pwdata[mcw_pkg::NDIM_W-1:0];
        mcw_pkg::REG_DIM_SIZES:    dim_sizes_q <= pwdata;
        mcw_pkg::REG_STRIDE_ZERO:  stride_q[0] <= pwdata[mcw_pkg::INDEX_W-1:0];
        mcw_pkg::REG_STRIDE_ONE:   stride_q[1] <= pwdata[mcw_pkg::INDEX_W-1:0];
        mcw_pkg::REG_STRIDE_TWO:   stride_q[2] <= pwdata[mcw_pkg::INDEX_W-1:0];
        mcw_pkg::REG_STRIDE_THREE: stride_q[3] <= pwdata[mcw_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (addr_idx)
      mcw_pkg::REG_NUM_DIMS:     prdata = {{(mcw_pkg::CFG_DATA_W-mcw_pkg::NDIM_W){1'b0}},
                                           num_dims_q};
      mcw_pkg::REG_DIM_SIZES:    prdata = dim_sizes_q;
      mcw_pkg::REG_STRIDE_ZERO:  prdata = {32'd0, stride_q[0]};
      mcw_pkg::REG_STRIDE_ONE:   prdata = {32'd0, stride_q[1]};
      mcw_pkg::REG_STRIDE_TWO:   prdata = {32'd0, stride_q[2]};
      mcw_pkg::REG_STRIDE_THREE: prdata = {32'd0, stride_q[3]};
      default:                   prdata = '0;
    endcase
  end

  assign num_dims_o  = num_dims_q;
  assign dim_sizes_o = dim_sizes_q;
  assign stride_o    = stride_q;

endmodule

// File: hdl/mcw_prep.sv
module mcw_prep #(
  parameter int MAX_DIMS  = mcw_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = mcw_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [MAX_DIMS-1:0][mcw_pkg::COORD_W-1:0]   coord_i,
  input  logic                                        margin_i,
  input  logic [mcw_pkg::NDIM_W-1:0]                  num_dims_i,
  input  logic [MAX_DIMS-1:0][mcw_pkg::SIZE_W-1:0]    size_i,
  input  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0]   stride_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [MAX_DIMS-1:0][FRAC_BITS-1:0]          frac_o,
  output logic [MAX_DIMS-1:0]                         dim_en_o,
  output logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0]   lo_term_o,
  output logic [(1<<MAX_DIMS)-1:0]                    mask_o,
  output logic [mcw_pkg::COUNT_W-1:0]                 count_o
);

  localparam int CORNERS = 1 << MAX_DIMS;
  localparam int FL_W    = mcw_pkg::COORD_W - FRAC_BITS;
  localparam int CW      = (FL_W + 2 > mcw_pkg::SIZE_W + 1) ? FL_W + 2 : mcw_pkg::SIZE_W + 1;

  // stage 1: captured word
  logic                                      v1_q;
  logic [MAX_DIMS-1:0][mcw_pkg::COORD_W-1:0] coord1_q;
  logic                                      margin1_q;
  // stage 2: floor, fraction, per-dimension bound checks
  logic                                      v2_q;
  logic [MAX_DIMS-1:0][FL_W-1:0]             fl2_q;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac2_q;
  logic [MAX_DIMS-1:0]                       lo_ok2_q, hi_ok2_q, en2_q;
  logic [MAX_DIMS-1:0][FL_W-1:0]             fl2_d;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac2_d;
  logic [MAX_DIMS-1:0]                       lo_ok2_d, hi_ok2_d, en2_d;
  // stage 3: stride products, corner mask, count
  logic                                      v3_q;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac3_q;
  logic [MAX_DIMS-1:0]                       en3_q;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] term3_q, term3_d;
  logic [CORNERS-1:0]                        mask3_q, mask3_d;
  logic [mcw_pkg::COUNT_W-1:0]               count3_q, count3_d;

  logic rdy1, rdy2, rdy3;
  logic [mcw_pkg::NDIM_W-1:0] n_eff;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    if (num_dims_i == '0) begin
      n_eff = mcw_pkg::NDIM_W'(1);
    end else if (num_dims_i > mcw_pkg::NDIM_W'(MAX_DIMS)) begin
      n_eff = mcw_pkg::NDIM_W'(MAX_DIMS);
    end else begin
      n_eff = num_dims_i;
    end
  end

  always_comb begin
    logic [CW-1:0] dc_lo, dc_hi, size_x, m_x;
    for (int d = 0; d < MAX_DIMS; d++) begin
      fl2_d[d]   = coord1_q[d][mcw_pkg::COORD_W-1:FRAC_BITS];
      frac2_d[d] = coord1_q[d][FRAC_BITS-1:0];
      dc_lo      = {{(CW-FL_W){fl2_d[d][FL_W-1]}}, fl2_d[d]};
      dc_hi      = dc_lo + CW'(1);
      size_x     = {{(CW-mcw_pkg::SIZE_W){1'b0}}, size_i[d]};
      m_x        = {{(CW-1){1'b0}}, margin1_q};
      lo_ok2_d[d] = !dc_lo[CW-1] && ((dc_lo + m_x) < size_x);
      hi_ok2_d[d] = !dc_hi[CW-1] && ((dc_hi + m_x) < size_x);
      en2_d[d]    = mcw_pkg::NDIM_W'(d) < n_eff;
    end
  end

  always_comb begin
    logic ok;
    logic [mcw_pkg::INDEX_W-1:0] fl_x;
    for (int d = 0; d < MAX_DIMS; d++) begin
      fl_x     = {{FRAC_BITS{fl2_q[d][FL_W-1]}}, fl2_q[d]};
      term3_d[d] = stride_i[d] * fl_x;
    end
    // bit d of the corner number picks the upper neighbour along dimension d
    count3_d = '0;
    for (int i = 0; i < CORNERS; i++) begin
      ok = 1'b1;
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (((i >> d) & 1) != 0) begin
          ok = ok && en2_q[d] && hi_ok2_q[d];
        end else begin
          ok = ok && (!en2_q[d] || lo_ok2_q[d]);
        end
      end
      mask3_d[i] = ok;
      count3_d   = count3_d + mcw_pkg::COUNT_W'(ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      coord1_q  <= coord_i;
      margin1_q <= margin_i;
    end
    if (rdy2 && v1_q) begin
      fl2_q    <= fl2_d;
      frac2_q  <= frac2_d;
      lo_ok2_q <= lo_ok2_d;
      hi_ok2_q <= hi_ok2_d;
      en2_q    <= en2_d;
    end
    if (rdy3 && v2_q) begin
      frac3_q  <= frac2_q;
      en3_q    <= en2_q;
      term3_q  <= term3_d;
      mask3_q  <= mask3_d;
      count3_q <= count3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign frac_o      = frac3_q;
  assign dim_en_o    = en3_q;
  assign lo_term_o   = term3_q;
  assign mask_o      = mask3_q;
  assign count_o     = count3_q;

endmodule

// File: hdl/mcw_corner_seq.sv
module mcw_corner_seq #(
  parameter int MAX_DIMS  = mcw_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = mcw_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac_i,
  input  logic [MAX_DIMS-1:0]                       dim_en_i,
  input  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] lo_term_i,
  input  logic [(1<<MAX_DIMS)-1:0]                  mask_i,
  input  logic [mcw_pkg::COUNT_W-1:0]               count_i,
  input  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] stride_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac_o,
  output logic [MAX_DIMS-1:0]                       dim_en_o,
  output logic [MAX_DIMS-1:0]                       hi_sel_o,
  output logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] term_o,
  output mcw_pkg::corner_ctl_t                      ctl_o
);

  localparam int CORNERS = 1 << MAX_DIMS;

  // held item
  logic                                      hv_q;
  logic [CORNERS-1:0]                        rem_q;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac_q;
  logic [MAX_DIMS-1:0]                       en_q;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] lo_q, hi_q, hi_d;
  logic [mcw_pkg::COUNT_W-1:0]               cnt_q;
  // corner word register
  logic                                      ov_q;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        ofrac_q;
  logic [MAX_DIMS-1:0]                       oen_q, ohi_q, ohi_d;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] oterm_q, oterm_d;
  mcw_pkg::corner_ctl_t                      octl_q, octl_d;

  logic [CORNERS-1:0]  pick, rest;
  logic [MAX_DIMS-1:0] cidx;
  logic                none, last, move, emit, load;

  // lowest remaining inside corner
  assign pick = rem_q & (~rem_q + CORNERS'(1));
  assign rest = rem_q & ~pick;
  assign none = (cnt_q == '0);
  assign last = none || (rest == '0);
  assign move = !ov_q || out_ready_i;
  assign emit = hv_q && move;
  assign in_ready_o = !hv_q || (emit && last);
  assign load = in_valid_i && in_ready_o;

  always_comb begin
    cidx = '0;
    for (int i = 0; i < CORNERS; i++) begin
      if (pick[i]) cidx = cidx | MAX_DIMS'(i);
    end
  end

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      hi_d[d]  = lo_term_i[d] + stride_i[d];
      ohi_d[d] = !none && cidx[d];
      if (none || !en_q[d]) begin
        oterm_d[d] = '0;
      end else begin
        oterm_d[d] = cidx[d] ? hi_q[d] : lo_q[d];
      end
    end
    octl_d.last  = last;
    octl_d.none  = none;
    octl_d.count = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        hv_q <= 1'b1;
      end else if (emit && last) begin
        hv_q <= 1'b0;
      end
      if (move) ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q  <= mask_i;
      frac_q <= frac_i;
      en_q   <= dim_en_i;
      lo_q   <= lo_term_i;
      hi_q   <= hi_d;
      cnt_q  <= count_i;
    end else if (emit) begin
      rem_q <= rest;
    end
    if (emit) begin
      ofrac_q <= frac_q;
      oen_q   <= en_q;
      ohi_q   <= ohi_d;
      oterm_q <= oterm_d;
      octl_q  <= octl_d;
    end
  end

  assign out_valid_o = ov_q;
  assign frac_o      = ofrac_q;
  assign dim_en_o    = oen_q;
  assign hi_sel_o    = ohi_q;
  assign term_o      = oterm_q;
  assign ctl_o       = octl_q;

endmodule

// File: hdl/mcw_weight.sv
module mcw_weight #(
  parameter int MAX_DIMS  = mcw_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = mcw_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac_i,
  input  logic [MAX_DIMS-1:0]                       dim_en_i,
  input  logic [MAX_DIMS-1:0]                       hi_sel_i,
  input  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] term_i,
  input  mcw_pkg::corner_ctl_t                      ctl_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [mcw_pkg::INDEX_W-1:0]               index_o,
  output logic [mcw_pkg::WEIGHT_W-1:0]              weight_o,
  output mcw_pkg::corner_ctl_t                      ctl_o
);

  localparam int W_W = FRAC_BITS + 1;
  localparam int P_W = 2 * W_W;
  localparam logic [W_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [P_W-1:0] HALF = {{(P_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // stage inputs (index s) and stage registers: stage s folds in dimension s
  logic                                      sv   [MAX_DIMS];
  logic [W_W-1:0]                            sw   [MAX_DIMS];
  logic [mcw_pkg::INDEX_W-1:0]               sidx [MAX_DIMS];
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        sfrac[MAX_DIMS];
  logic [MAX_DIMS-1:0]                       sen  [MAX_DIMS];
  logic [MAX_DIMS-1:0]                       shi  [MAX_DIMS];
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] sterm[MAX_DIMS];
  mcw_pkg::corner_ctl_t                      sctl [MAX_DIMS];

  logic                                      v_q   [MAX_DIMS];
  logic [W_W-1:0]                            w_q   [MAX_DIMS];
  logic [mcw_pkg::INDEX_W-1:0]               idx_q [MAX_DIMS];
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        frac_q[MAX_DIMS];
  logic [MAX_DIMS-1:0]                       en_q  [MAX_DIMS];
  logic [MAX_DIMS-1:0]                       hi_q  [MAX_DIMS];
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] term_q[MAX_DIMS];
  mcw_pkg::corner_ctl_t                      ctl_q [MAX_DIMS];

  logic                  rdy [MAX_DIMS];
  logic                  out_move;

  logic                                ov_q;
  logic [mcw_pkg::INDEX_W-1:0]         oidx_q, oidx_d;
  logic [mcw_pkg::WEIGHT_W-1:0]        ow_q, ow_d, q16;
  mcw_pkg::corner_ctl_t                octl_q;

  assign out_move   = !ov_q || out_ready_i;
  assign in_ready_o = rdy[0];

  for (genvar s = 0; s < MAX_DIMS; s++) begin : g_stage
    logic [W_W-1:0]              w_d;
    logic [mcw_pkg::INDEX_W-1:0] idx_d;

    if (s == 0) begin : g_head
      always_comb begin
        sv[s]    = in_valid_i;
        sw[s]    = ONE;
        sidx[s]  = '0;
        sfrac[s] = frac_i;
        sen[s]   = dim_en_i;
        shi[s]   = hi_sel_i;
        sterm[s] = term_i;
        sctl[s]  = ctl_i;
      end
    end else begin : g_body
      always_comb begin
        sv[s]    = v_q[s-1];
        sw[s]    = w_q[s-1];
        sidx[s]  = idx_q[s-1];
        sfrac[s] = frac_q[s-1];
        sen[s]   = en_q[s-1];
        shi[s]   = hi_q[s-1];
        sterm[s] = term_q[s-1];
        sctl[s]  = ctl_q[s-1];
      end
    end

    if (s == MAX_DIMS - 1) begin : g_tail
      assign rdy[s] = !v_q[s] || out_move;
    end else begin : g_mid
      assign rdy[s] = !v_q[s] || rdy[s+1];
    end

    always_comb begin
      logic [W_W-1:0] f;
      logic [P_W-1:0] prod;
      f    = shi[s][s] ? {1'b0, sfrac[s][s]} : ONE - {1'b0, sfrac[s][s]};
      prod = P_W'(sw[s]) * P_W'(f) + HALF;
      w_d  = sen[s][s] ? prod[FRAC_BITS +: W_W] : sw[s];
      idx_d = sidx[s] + sterm[s][s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= sv[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && sv[s]) begin
        w_q[s]    <= w_d;
        idx_q[s]  <= idx_d;
        frac_q[s] <= sfrac[s];
        en_q[s]   <= sen[s];
        hi_q[s]   <= shi[s];
        term_q[s] <= sterm[s];
        ctl_q[s]  <= sctl[s];
      end
    end
  end

  // bring the weight to Q1.16
  if (FRAC_BITS > 16) begin : g_round
    localparam logic [W_W-1:0] RND = W_W'(1) << (FRAC_BITS - 17);
    logic [W_W-1:0] wr;
    assign wr  = w_q[MAX_DIMS-1] + RND;
    assign q16 = wr[FRAC_BITS-16 +: mcw_pkg::WEIGHT_W];
  end else if (FRAC_BITS == 16) begin : g_keep
    assign q16 = w_q[MAX_DIMS-1][mcw_pkg::WEIGHT_W-1:0];
  end else begin : g_widen
    assign q16 = {w_q[MAX_DIMS-1], {(16-FRAC_BITS){1'b0}}};
  end

  assign ow_d   = ctl_q[MAX_DIMS-1].none ? '0 : q16;
  assign oidx_d = ctl_q[MAX_DIMS-1].none ? '0 : idx_q[MAX_DIMS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_move) begin
      ov_q <= v_q[MAX_DIMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move && v_q[MAX_DIMS-1]) begin
      oidx_q <= oidx_d;
      ow_q   <= ow_d;
      octl_q <= ctl_q[MAX_DIMS-1];
    end
  end

  assign out_valid_o = ov_q;
  assign index_o     = oidx_q;
  assign weight_o    = ow_q;
  assign ctl_o       = octl_q;

endmodule

// File: hdl/multilinear_corner_weights.sv
// channel     | direction | fields (low bit first)
// ------------+-----------+----------------------------------------------------------
// s_axis      | in        | tdata: coord_zero, coord_one, coord_two, coord_three; tuser: margin
// m_axis      | out       | tdata: sample_index, weight, sample_count; tlast: is_last;
//             |           | tuser: none_inside
// apb         | in/out    | 64-bit registers at 8*i: num_dims, dim_sizes, strides 0..3
//
// One position yields max(1, inside corners) corner words, 1 to 2^MAX_DIMS; the corner
// sequencer emits one corner word per cycle while m_axis is not stalled, and takes the
// next position as it emits the last corner word of the current one.
// rst_ni clears all valid bits and loads the register defaults at once.
// m_axis_tready low freezes the pipe stage by stage and backs up into s_axis_tready.
module multilinear_corner_weights #(
  parameter int MAX_DIMS  = mcw_pkg::MAX_DIMS_DEF,
  parameter int FRAC_BITS = mcw_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [mcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // coord_zero .. coord_three
  input  logic                             s_axis_tuser,  // margin
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // sample_index, weight,
                                                          // sample_count, zero fill
  output logic                             m_axis_tlast,  // is_last
  output logic                             m_axis_tuser,  // none_inside
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mcw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [mcw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [mcw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [mcw_pkg::NDIM_W-1:0]                               num_dims;
  logic [mcw_pkg::NUM_COORDS*mcw_pkg::SIZE_W-1:0]           dim_sizes;
  logic [mcw_pkg::NUM_COORDS-1:0][mcw_pkg::INDEX_W-1:0]     stride_all;

  logic [MAX_DIMS-1:0][mcw_pkg::COORD_W-1:0] coord;
  logic [MAX_DIMS-1:0][mcw_pkg::SIZE_W-1:0]  size;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] stride;

  logic                                      pv, pr;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        p_frac;
  logic [MAX_DIMS-1:0]                       p_en;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] p_lo;
  logic [(1<<MAX_DIMS)-1:0]                  p_mask;
  logic [mcw_pkg::COUNT_W-1:0]               p_count;

  logic                                      cv, cr;
  logic [MAX_DIMS-1:0][FRAC_BITS-1:0]        c_frac;
  logic [MAX_DIMS-1:0]                       c_en, c_hi;
  logic [MAX_DIMS-1:0][mcw_pkg::INDEX_W-1:0] c_term;
  mcw_pkg::corner_ctl_t                      c_ctl;

  logic [mcw_pkg::INDEX_W-1:0]               o_index;
  logic [mcw_pkg::WEIGHT_W-1:0]              o_weight;
  mcw_pkg::corner_ctl_t                      o_ctl;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    assign coord[d]  = s_axis_tdata[mcw_pkg::COORD_W*d +: mcw_pkg::COORD_W];
    assign size[d]   = dim_sizes[mcw_pkg::SIZE_W*d +: mcw_pkg::SIZE_W];
    assign stride[d] = stride_all[d];
  end

  mcw_regs u_regs (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .num_dims_o  (num_dims),
    .dim_sizes_o (dim_sizes),
    .stride_o    (stride_all)
  );

  mcw_prep #(.MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .coord_i     (coord),
    .margin_i    (s_axis_tuser),
    .num_dims_i  (num_dims),
    .size_i      (size),
    .stride_i    (stride),
    .out_valid_o (pv),
    .out_ready_i (pr),
    .frac_o      (p_frac),
    .dim_en_o    (p_en),
    .lo_term_o   (p_lo),
    .mask_o      (p_mask),
    .count_o     (p_count)
  );

  mcw_corner_seq #(.MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS)) u_seq (
    .clk_i, .rst_ni,
    .in_valid_i  (pv),
    .in_ready_o  (pr),
    .frac_i      (p_frac),
    .dim_en_i    (p_en),
    .lo_term_i   (p_lo),
    .mask_i      (p_mask),
    .count_i     (p_count),
    .stride_i    (stride),
    .out_valid_o (cv),
    .out_ready_i (cr),
    .frac_o      (c_frac),
    .dim_en_o    (c_en),
    .hi_sel_o    (c_hi),
    .term_o      (c_term),
    .ctl_o       (c_ctl)
  );

  mcw_weight #(.MAX_DIMS(MAX_DIMS), .FRAC_BITS(FRAC_BITS)) u_weight (
    .clk_i, .rst_ni,
    .in_valid_i  (cv),
    .in_ready_o  (cr),
    .frac_i      (c_frac),
    .dim_en_i    (c_en),
    .hi_sel_i    (c_hi),
    .term_i      (c_term),
    .ctl_i       (c_ctl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .index_o     (o_index),
    .weight_o    (o_weight),
    .ctl_o       (o_ctl)
  );

  assign m_axis_tdata = {{(mcw_pkg::OUT_DATA_W - mcw_pkg::INDEX_W - mcw_pkg::WEIGHT_W
                           - mcw_pkg::COUNT_W){1'b0}},
                         o_ctl.count, o_weight, o_index};
  assign m_axis_tlast = o_ctl.last;
  assign m_axis_tuser = o_ctl.none;

endmodule

// File: hdl/mcw_checker.sv
module mcw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser
);

  logic [mcw_pkg::WEIGHT_W-1:0] weight;
  logic [mcw_pkg::COUNT_W-1:0]  count;

  assign weight = m_axis_tdata[48:32];
  assign count  = m_axis_tdata[53:49];

  // an empty result stands alone and carries nothing
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("empty result not closed or not zero");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (count != '0) && (count <= 5'd16))
    else $error("corner count out of range");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> weight <= 17'h10000)
    else $error("weight above one");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled word changed");

endmodule

bind multilinear_corner_weights mcw_checker u_mcw_checker (.*);

// File: sim/multilinear_corner_weights_test.sv
`timescale 1ns / 100ps

module multilinear_corner_weights_test;

  localparam int FRAC        = mcw_pkg::FRAC_BITS_DEF;
  localparam int MAXD        = mcw_pkg::MAX_DIMS_DEF;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int PER_LATTICE = 26;

  typedef struct packed {
    logic [mcw_pkg::INDEX_W-1:0]  index;
    logic [mcw_pkg::WEIGHT_W-1:0] weight;
    logic [mcw_pkg::COUNT_W-1:0]  count;
    logic                         last;
    logic                         empty;
  } corner_word_t;

  typedef struct packed {
    logic [mcw_pkg::NDIM_W-1:0] dims;
    logic [63:0]                sizes;   // size 0 in bits 15:0
    logic [127:0]               strides; // stride 0 in bits 31:0
  } lattice_t;

  typedef struct packed {
    logic [3:0]   lattice;
    logic [127:0] pos;     // coord 0 in bits 31:0
    logic         margin;
    logic         typed;   // expect the empty-lattice word
  } probe_t;

  localparam corner_word_t EMPTY_LATTICE = '{index: '0, weight: '0, count: '0,
                                             last: 1'b1, empty: 1'b1};

  localparam lattice_t LATTICES [9] = '{
    '{3'd1, 64'h0, {32'd0, 32'd0, 32'd0, 32'd1}},
    '{3'd1, 64'h0000_0000_0000_0010, {32'd0, 32'd0, 32'd0, 32'd1}},
    '{3'd2, 64'h0000_0000_0008_0008, {32'd0, 32'd0, 32'd8, 32'd1}},
    '{3'd3, 64'h0000_0006_0005_0004, {32'd0, 32'd20, 32'd4, 32'd1}},
    '{3'd4, 64'h0003_0003_0003_0003, {32'd27, 32'd9, 32'd3, 32'd1}},
    '{3'd4, 64'hFFFF_FFFF_FFFF_FFFF, {4{32'hFFFF_FFFF}}},
    '{3'd0, 64'h0000_0000_0000_000A, {32'd0, 32'd0, 32'd0, 32'd7}},
    '{3'd7, 64'h0002_0002_0002_0002, {32'd8, 32'd4, 32'd2, 32'd1}},
    '{3'd4, 64'h0005_0000_0005_0005, {4{32'd0}}}
  };

  localparam probe_t PROBES [21] = '{
    '{4'd0, {4{32'h0000_0000}}, 1'b0, 1'b1},
    '{4'd0, {4{32'h7FFF_FFFF}}, 1'b1, 1'b1},
    '{4'd0, {4{32'h8000_0000}}, 1'b0, 1'b1},
    '{4'd1, {96'h0, 32'h0000_0000}, 1'b0, 1'b0},
    '{4'd1, {96'h0, 32'h0000_8000}, 1'b1, 1'b0},
    '{4'd1, {96'h0, 32'hFFFF_8000}, 1'b0, 1'b0},
    '{4'd1, {96'h0, 32'h000F_0000}, 1'b1, 1'b1},
    '{4'd1, {96'h0, 32'h000E_FFFF}, 1'b1, 1'b0},
    '{4'd1, {96'h0, 32'h7FFF_FFFF}, 1'b0, 1'b1},
    '{4'd1, {96'h0, 32'h8000_0000}, 1'b0, 1'b1},
    '{4'd2, {64'h0, 32'h0003_4000, 32'h0002_C000}, 1'b0, 1'b0},
    '{4'd2, {64'h0, 32'h0007_8000, 32'hFFFF_FFFF}, 1'b0, 1'b0},
    '{4'd3, {32'h0, 32'h0005_1234, 32'h0004_8000, 32'h0003_FFFF}, 1'b0, 1'b0},
    '{4'd4, {32'h0001_8000, 32'h0001_4000, 32'h0001_C000, 32'h0001_0001}, 1'b0, 1'b0},
    '{4'd4, {32'h0001_8000, 32'h0001_4000, 32'h0001_C000, 32'h0001_0001}, 1'b1, 1'b0},
    '{4'd5, {4{32'h7FFF_FFFF}}, 1'b1, 1'b0},
    '{4'd5, {4{32'hFFFF_FFFF}}, 1'b0, 1'b0},
    '{4'd6, {32'hDEAD_BEEF, 32'h1234_5678, 32'hFFFF_0000, 32'h0004_8000}, 1'b0, 1'b0},
    '{4'd7, {4{32'h0000_8000}}, 1'b0, 1'b0},
    '{4'd7, {4{32'h0000_0000}}, 1'b1, 1'b0},
    '{4'd8, {4{32'h0001_0000}}, 1'b0, 1'b1}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [mcw_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [mcw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [mcw_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [mcw_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [mcw_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  // register shadow used for prediction
  logic [mcw_pkg::NDIM_W-1:0] cur_dims = mcw_pkg::NUM_DIMS_RST;
  logic [63:0]                cur_sizes = '0;
  logic [3:0][31:0]           cur_strides = {32'd0, 32'd0, 32'd0, mcw_pkg::STRIDE0_RST};

  corner_word_t pending_corners [$];
  int  fails = 0;
  int  positions_sent = 0;
  int  words_checked = 0;
  int  empty_words = 0;
  int  full_sets = 0;
  int  lattices_used = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  multilinear_corner_weights DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Expand one position into its inside corners under the current registers.
  function automatic void weigh_corners(input logic [127:0] pos, input logic margin);
    longint            fl [4];
    longint unsigned   frac [4];
    longint unsigned   one;
    longint unsigned   w;
    longint unsigned   f;
    longint            dc;
    longint            size;
    logic [31:0]       idx;
    bit                in_lattice;
    int                n;
    int                up;
    corner_word_t      found [$];
    corner_word_t      word;
    one = 64'd1 << FRAC;
    n = cur_dims;
    if (n < 1) n = 1;
    if (n > MAXD) n = MAXD;
    for (int d = 0; d < n; d++) begin
      frac[d] = pos[32*d +: FRAC];
      fl[d] = longint'($signed(pos[32*d +: 32])) >>> FRAC;
    end
    for (int corner = 0; corner < (1 << n); corner++) begin
      idx = '0;
      w = one;
      in_lattice = 1'b1;
      for (int d = 0; d < n; d++) begin
        up = corner[d];
        dc = fl[d] + up;
        size = longint'(cur_sizes[16*d +: 16]);
        f = up ? frac[d] : one - frac[d];
        // round to nearest, ties up
        w = (w * f + (one >> 1)) >> FRAC;
        if (dc < 0 || dc + longint'(margin) >= size) in_lattice = 1'b0;
        else idx = idx + cur_strides[d] * dc[31:0];
      end
      if (in_lattice) begin
        word = '0;
        word.index = idx;
        word.weight = w[mcw_pkg::WEIGHT_W-1:0];
        found = {found, word};
      end
    end
    if (found.size() == 0) begin
      pending_corners = {pending_corners, EMPTY_LATTICE};
    end else begin
      foreach (found[i]) begin
        found[i].count = mcw_pkg::COUNT_W'(found.size());
        found[i].last = (i == found.size() - 1);
        pending_corners = {pending_corners, found[i]};
      end
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with tvalid still set.
  task automatic send_position(input logic [127:0] pos, input logic margin, input logic typed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata = pos;
    s_axis_tuser = margin;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) pending_corners = {pending_corners, EMPTY_LATTICE};
    else weigh_corners(pos, margin);
    positions_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_corners;
    s_axis_tvalid = 1'b0;
    while (pending_corners.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_access(input mcw_pkg::reg_idx_e r, input logic wr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {r, 3'b000};
    pwdata = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_lattice(input lattice_t lat);
    mcw_pkg::reg_idx_e regs [6];
    logic [63:0]       vals [6];
    logic [63:0]       rd;
    regs = '{mcw_pkg::REG_NUM_DIMS, mcw_pkg::REG_DIM_SIZES, mcw_pkg::REG_STRIDE_ZERO,
             mcw_pkg::REG_STRIDE_ONE, mcw_pkg::REG_STRIDE_TWO, mcw_pkg::REG_STRIDE_THREE};
    vals = '{64'(lat.dims), lat.sizes, 64'(lat.strides[31:0]), 64'(lat.strides[63:32]),
             64'(lat.strides[95:64]), 64'(lat.strides[127:96])};
    for (int i = 0; i < 6; i++) begin
      apb_access(regs[i], 1'b1, vals[i], rd);
      apb_access(regs[i], 1'b0, '0, rd);
      if (rd !== vals[i]) begin
        $display("%0t: register %s read back: expected %h, actual %h",
                 $time, regs[i].name(), vals[i], rd);
        fails++;
      end
    end
    cur_dims = lat.dims;
    cur_sizes = lat.sizes;
    cur_strides = lat.strides;
    lattices_used++;
  endtask

  function automatic lattice_t random_lattice();
    lattice_t lat;
    lat.dims = ($urandom_range(9) < 8) ? mcw_pkg::NDIM_W'($urandom_range(1, MAXD))
                                       : mcw_pkg::NDIM_W'($urandom_range(7));
    for (int d = 0; d < 4; d++) begin
      case ($urandom_range(9))
        0:       lat.sizes[16*d +: 16] = '0;
        1:       lat.sizes[16*d +: 16] = 16'($urandom_range(65535));
        default: lat.sizes[16*d +: 16] = 16'($urandom_range(1, 6));
      endcase
      lat.strides[32*d +: 32] = ($urandom_range(9) < 7) ? 32'($urandom_range(64)) : $urandom;
    end
    return lat;
  endfunction

  // Mostly positions around the lattice so corners land inside; some raw noise.
  function automatic logic [127:0] random_position();
    logic [127:0] pos;
    int           fl;
    logic [15:0]  frac;
    for (int d = 0; d < 4; d++) begin
      if ($urandom_range(9) < 8) begin
        fl = int'($urandom_range(int'(cur_sizes[16*d +: 16]) + 1)) - 1;
        case ($urandom_range(3))
          0:       frac = 16'h0000;
          1:       frac = 16'hFFFF;
          default: frac = 16'($urandom_range(65535));
        endcase
        pos[32*d +: 32] = {fl[15:0], frac};
      end else begin
        pos[32*d +: 32] = $urandom;
      end
    end
    return pos;
  endfunction

  function automatic void check_field(input string name, input longint unsigned expected,
                                      input longint unsigned actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expected, actual);
      fails++;
    end
  endfunction

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    corner_word_t exp_word;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (pending_corners.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual index %0d weight %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[48:32]);
        fails++;
      end else begin
        exp_word = pending_corners.pop_front();
        check_field("sample_index", exp_word.index, m_axis_tdata[31:0]);
        check_field("weight", exp_word.weight, m_axis_tdata[48:32]);
        check_field("sample_count", exp_word.count, m_axis_tdata[53:49]);
        check_field("is_last", exp_word.last, m_axis_tlast);
        check_field("none_inside", exp_word.empty, m_axis_tuser);
        if (exp_word.empty) empty_words++;
        if (exp_word.last && exp_word.count == 16) full_sets++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words outstanding",
               $time, QUIET_LIMIT, pending_corners.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int       showcase [4];
    int       idle_phases [4][2];
    int       lattice_sel;
    lattice_t lat;
    showcase = '{4, 5, 7, 2};
    idle_phases = '{'{0, 0}, '{69, 0}, '{0, 69}, '{36, 36}};
    lattice_sel = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (PROBES[i]) begin
      if (PROBES[i].lattice != lattice_sel) begin
        drain_corners();
        lattice_sel = PROBES[i].lattice;
        load_lattice(LATTICES[lattice_sel]);
      end
      send_position(PROBES[i].pos, PROBES[i].margin, PROBES[i].typed);
    end

    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) begin
        // pause the sender until the block has emptied, then retune
        drain_corners();
        send_idle_pct = idle_phases[p][0];
        recv_stall_pct = idle_phases[p][1];
        lat = (k == 0) ? LATTICES[showcase[p]] : random_lattice();
        load_lattice(lat);
        if (p == 0 && k == 0) hold_req = 1'b1;
        repeat (PER_LATTICE) send_position(random_position(), 1'($urandom_range(1)), 1'b0);
      end
    end

    drain_corners();
    repeat (MAXD + 10) @(posedge clk_i);
    $display("Sent %0d positions over %0d lattice setups and four idle mixes;",
             positions_sent, lattices_used);
    $display("checked %0d corner words, %0d empty-lattice, %0d full 16-corner sets.",
             words_checked, empty_words, full_sets);
    if (fails == 0 && pending_corners.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
